### rtl/gssc_pkg.sv
// ----------------------------------------------------------------------------
// gssc_pkg
// Shared types, constants and helpers for the same-symbol cycle detector.
// ----------------------------------------------------------------------------
package gssc_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int DEPTH_W  = $clog2(CELLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int DIM_W    = 7;
    localparam int SYM_W    = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    // neighbor directions; DIR_NONE marks a root (no parent) or an exhausted frame
    localparam logic [2:0] DIR_DOWN  = 3'd0;
    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_UP    = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_NONE  = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       pdir;
        logic [2:0]       nxt;
    } t_frame;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_LOAD,
        S_SCAN,
        S_SCAN_CHK,
        S_STEP,
        S_NB_CHK,
        S_POP_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load_en;
        logic scan_rd;
        logic scan_chk;
        logic step;
        logic nb_chk;
        logic pop_load;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic last_accept;
        logic scan_end;
        logic root_vis;
        logic exhausted;
        logic depth_one;
        logic nb_ok;
        logic out_busy;
    } t_status;

    // 0 counts as 1, above the maximum counts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

### rtl/grid_same_symbol_cycle_detect_unit.sv
// ----------------------------------------------------------------------------
// grid_same_symbol_cycle_detect_unit
// Loads a symbol grid and reports whether a same-symbol 4-connected cycle exists.
// ----------------------------------------------------------------------------
// Load: one cell request per cycle. Walk: every cell passes through a scan read
//   and a scan check; each visited cell adds step states, a check per in-bounds
//   non-parent neighbor and, unless it is a root, a pop wait, all serialized by
//   the single visited/grid read port. The result loads in S_DONE after the scan,
//   once the previous result has been taken. Clearing pass over every cell after
// reset and over row_count*col_count cells after each result; no cell request is
// taken meanwhile. Reset: synchronous, active low; config resets to 64 x 64.
module grid_same_symbol_cycle_detect_unit
    import gssc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DIM_W-1:0]      i_cfg_data,
    // cell requests
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SYM_W-1:0]      i_cell_symbol,
    input  logic                  i_last_cell,
    // result request
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_has_cycle
);

    t_cmd    cmd;
    t_status st;

    // sequencer: clear -> load -> scan/walk -> result
    gssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // memories, stack top, scan position and result register
    gssc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_symbol (i_cell_symbol),
        .i_last_cell   (i_last_cell),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_has_cycle   (o_has_cycle)
    );

endmodule

### rtl/gssc_ctrl.sv
// ----------------------------------------------------------------------------
// gssc_ctrl
// Sequencer for load, clear and depth-first walk phases.
// ----------------------------------------------------------------------------
module gssc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gssc_pkg::t_status i_st,
    output gssc_pkg::t_cmd    o_cmd
);
    import gssc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_st.clr_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_st.last_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_state = i_st.scan_end ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = i_st.root_vis ? S_SCAN : S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_st.exhausted)  n_state = i_st.depth_one ? S_SCAN : S_POP_WAIT;
                else if (i_st.nb_ok) n_state = S_NB_CHK;
            end
            S_NB_CHK: begin
                o_cmd.nb_chk = 1'b1;
                n_state = S_STEP;
            end
            S_POP_WAIT: begin
                o_cmd.pop_load = 1'b1;
                n_state = S_STEP;
            end
            S_DONE: begin
                if (!i_st.out_busy) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

### rtl/gssc_dp.sv
// ----------------------------------------------------------------------------
// gssc_dp
// Grid, visited and stack memories, walk registers and result register.
// ----------------------------------------------------------------------------
module gssc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gssc_pkg::t_cmd                  i_cmd,
    output gssc_pkg::t_status               o_st,
    input  logic                            i_cfg_we,
    input  logic [gssc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gssc_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gssc_pkg::SYM_W-1:0]      i_cell_symbol,
    input  logic                            i_last_cell,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_has_cycle
);
    import gssc_pkg::*;

    localparam logic [DIM_W-1:0] ROWS_HI = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] COLS_HI = DIM_W'(MAX_COLS);

    // config
    logic [DIM_W-1:0]   r_rows_cfg, r_cols_cfg;
    // dims latched at the last cell
    logic [DIM_W-1:0]   r_rows, r_cols;
    logic [DEPTH_W-1:0] r_total;
    logic [DEPTH_W-1:0] r_clr_lim;
    logic [DEPTH_W-1:0] r_clr;
    logic [DEPTH_W-1:0] r_load_pos;
    logic [DEPTH_W-1:0] r_scan;
    logic [ROW_W-1:0]   r_scan_row;
    logic [COL_W-1:0]   r_scan_col;
    logic [DEPTH_W-1:0] r_depth;
    t_frame             r_top;
    logic [SYM_W-1:0]   r_sym;
    logic [ROW_W-1:0]   r_nb_row;
    logic [COL_W-1:0]   r_nb_col;
    logic [1:0]         r_nb_dir;
    logic [ADDR_W-1:0]  r_nb_addr;
    logic               r_cycle;
    logic               r_out_valid;
    logic               r_has_cycle;

    // memories
    logic [SYM_W-1:0]   r_grid_mem [CELLS];
    logic               r_vis_mem  [CELLS];
    t_frame             r_stk_mem  [CELLS];
    logic [SYM_W-1:0]   r_grid_q;
    logic               r_vis_q;
    t_frame             r_stk_q;

    logic [DIM_W-1:0]   cur_rows, cur_cols;
    logic [DEPTH_W-1:0] cur_total;
    logic               accept;
    logic               last_accept;

    logic               grid_we;
    logic               vis_we;
    logic [ADDR_W-1:0]  vis_wa;
    logic               vis_wd;
    logic [ADDR_W-1:0]  rd_addr;
    logic               stk_we;

    logic [1:0]         dir;
    logic               in_bounds;
    logic [ROW_W-1:0]   nb_row;
    logic [COL_W-1:0]   nb_col;
    logic [ADDR_W-1:0]  nb_addr;
    logic               exhausted;
    logic               nb_ok;
    logic               push;

    assign cur_rows    = clamp_dim(r_rows_cfg, ROWS_HI);
    assign cur_cols    = clamp_dim(r_cols_cfg, COLS_HI);
    assign cur_total   = DEPTH_W'(cur_rows * cur_cols);
    assign o_in_ready  = i_cmd.load_en;
    assign accept      = i_in_valid && i_cmd.load_en;
    assign last_accept = accept && i_last_cell;

    // neighbor of the top frame in the direction it tries next
    always_comb begin
        dir       = r_top.nxt[1:0];
        in_bounds = 1'b0;
        nb_row    = r_top.row;
        nb_col    = r_top.col;
        case ({1'b0, dir})
            DIR_DOWN: begin
                in_bounds = ({1'b0, r_top.row} + DIM_W'(1)) < r_rows;
                nb_row    = r_top.row + ROW_W'(1);
            end
            DIR_RIGHT: begin
                in_bounds = ({1'b0, r_top.col} + DIM_W'(1)) < r_cols;
                nb_col    = r_top.col + COL_W'(1);
            end
            DIR_UP: begin
                in_bounds = r_top.row != '0;
                nb_row    = r_top.row - ROW_W'(1);
            end
            default: begin
                in_bounds = r_top.col != '0;
                nb_col    = r_top.col - COL_W'(1);
            end
        endcase
        nb_addr   = ADDR_W'(nb_row * r_cols + {{(ADDR_W-COL_W){1'b0}}, nb_col});
        exhausted = r_top.nxt == DIR_NONE;
        nb_ok     = !exhausted && (r_top.nxt != r_top.pdir) && in_bounds;
    end

    assign push = i_cmd.nb_chk && (r_grid_q == r_sym) && !r_vis_q;

    // memory port control
    always_comb begin
        grid_we = accept && (r_load_pos < cur_total);
        vis_we  = 1'b0;
        vis_wa  = r_clr[ADDR_W-1:0];
        vis_wd  = 1'b0;
        if (i_cmd.clear_step) begin
            vis_we = 1'b1;
        end else if (i_cmd.scan_chk && !r_vis_q) begin
            vis_we = 1'b1;
            vis_wa = r_scan[ADDR_W-1:0];
            vis_wd = 1'b1;
        end else if (push) begin
            vis_we = 1'b1;
            vis_wa = r_nb_addr;
            vis_wd = 1'b1;
        end
        rd_addr = i_cmd.step ? nb_addr : r_scan[ADDR_W-1:0];
        stk_we  = push;
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) r_grid_mem[r_load_pos[ADDR_W-1:0]] <= i_cell_symbol;
        r_grid_q <= r_grid_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) r_vis_mem[vis_wa] <= vis_wd;
        r_vis_q <= r_vis_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[ADDR_W'(r_depth - DEPTH_W'(1))] <= r_top;
        r_stk_q <= r_stk_mem[ADDR_W'(r_depth - DEPTH_W'(2))];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg  <= ROWS_HI;
            r_cols_cfg  <= COLS_HI;
            r_clr       <= '0;
            r_clr_lim   <= DEPTH_W'(CELLS);
            r_load_pos  <= '0;
            r_depth     <= '0;
            r_cycle     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_ROWS) r_rows_cfg <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_COLS) r_cols_cfg <= i_cfg_data;

            if (i_cmd.clear_step)
                r_clr <= o_st.clr_last ? '0 : r_clr + DEPTH_W'(1);

            if (accept) begin
                if (i_last_cell) r_load_pos <= '0;
                else if (r_load_pos < cur_total) r_load_pos <= r_load_pos + DEPTH_W'(1);
            end
            if (last_accept) begin
                r_clr_lim <= cur_total;
                r_cycle   <= 1'b0;
            end

            if (i_cmd.scan_chk && !r_vis_q) r_depth <= DEPTH_W'(1);
            if (i_cmd.step && exhausted)    r_depth <= r_depth - DEPTH_W'(1);
            if (push)                       r_depth <= r_depth + DEPTH_W'(1);
            if (i_cmd.nb_chk && (r_grid_q == r_sym) && r_vis_q) r_cycle <= 1'b1;

            if (i_cmd.done)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (last_accept) begin
            r_rows     <= cur_rows;
            r_cols     <= cur_cols;
            r_total    <= cur_total;
            r_scan     <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end
        if (i_cmd.scan_chk) begin
            if (!r_vis_q) begin
                r_sym <= r_grid_q;
                r_top <= '{row: r_scan_row, col: r_scan_col, pdir: DIR_NONE, nxt: 3'd0};
            end
            r_scan <= r_scan + DEPTH_W'(1);
            if (({1'b0, r_scan_col} + DIM_W'(1)) == r_cols) begin
                r_scan_col <= '0;
                r_scan_row <= r_scan_row + ROW_W'(1);
            end else begin
                r_scan_col <= r_scan_col + COL_W'(1);
            end
        end
        if (i_cmd.step && !exhausted) begin
            r_top.nxt <= r_top.nxt + 3'd1;
            r_nb_row  <= nb_row;
            r_nb_col  <= nb_col;
            r_nb_dir  <= dir;
            r_nb_addr <= nb_addr;
        end
        if (push)
            r_top <= '{row: r_nb_row, col: r_nb_col,
                       pdir: {1'b0, r_nb_dir + 2'd2}, nxt: 3'd0};
        if (i_cmd.pop_load) r_top <= r_stk_q;
        if (i_cmd.done) r_has_cycle <= r_cycle;
    end

    always_comb begin
        o_st.clr_last    = r_clr == (r_clr_lim - DEPTH_W'(1));
        o_st.last_accept = last_accept;
        o_st.scan_end    = r_scan == r_total;
        o_st.root_vis    = r_vis_q;
        o_st.exhausted   = exhausted;
        o_st.depth_one   = r_depth == DEPTH_W'(1);
        o_st.nb_ok       = nb_ok;
        o_st.out_busy    = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

endmodule
